// File: src/dtl_pkg.sv
`default_nettype none
package dtl_pkg;

	localparam int DAC_BITS_DEF = 12;
	localparam int FRAC_BITS    = 4;

	localparam int TMV_W   = 15;
	localparam int MEAS_W  = 20;
	localparam int TGT_W   = 19;
	localparam int SP_W    = 24;
	localparam int ERR_W   = 21;
	localparam int CNT_W   = 8;
	localparam int TOL_W   = 16;
	localparam int GAIN_W  = 20;
	localparam int MIN_W   = 10;
	localparam int GAIN_FRAC = 20;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	localparam logic [2:0] REG_TOL  = 3'd0;
	localparam logic [2:0] REG_WIN  = 3'd1;
	localparam logic [2:0] REG_MAXC = 3'd2;
	localparam logic [2:0] REG_GAIN = 3'd3;
	localparam logic [2:0] REG_MINT = 3'd4;

	localparam logic [TOL_W-1:0]  TOL_RST  = 16'd80;
	localparam logic [TOL_W-1:0]  WIN_RST  = 16'd3200;
	localparam logic [CNT_W-1:0]  MAXC_RST = 8'd50;
	localparam logic [GAIN_W-1:0] GAIN_RST = 20'd14271;
	localparam logic [MIN_W-1:0]  MINT_RST = 10'd50;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_CAPTURE,
		PH_TRIM
	} phase_t;

	typedef enum logic [1:0] {
		ST_TRIM,
		ST_PASS,
		ST_FAIL,
		ST_IGNORED
	} status_t;

	typedef struct packed {
		logic [TOL_W-1:0]  tol;
		logic [TOL_W-1:0]  win;
		logic [CNT_W-1:0]  maxc;
		logic [GAIN_W-1:0] gain;
		logic [MIN_W-1:0]  mint;
	} cfg_t;

	typedef struct packed {
		logic                   load;
		logic signed [SP_W-1:0] sp;
		status_t                status;
	} dec_t;

endpackage
`default_nettype wire

// File: src/dtl_cfg.sv
`default_nettype none
module dtl_cfg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [dtl_pkg::ADDR_W-1:0] paddr,
	input  wire logic [dtl_pkg::DATA_W-1:0] pwdata,
	output logic      [dtl_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	output dtl_pkg::cfg_t                   cfg
);
	import dtl_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tol  <= TOL_RST;
			cfg_q.win  <= WIN_RST;
			cfg_q.maxc <= MAXC_RST;
			cfg_q.gain <= GAIN_RST;
			cfg_q.mint <= MINT_RST;
		end else if (wr) begin
			case (idx)
				REG_TOL:  cfg_q.tol  <= pwdata[TOL_W-1:0];
				REG_WIN:  cfg_q.win  <= pwdata[TOL_W-1:0];
				REG_MAXC: cfg_q.maxc <= pwdata[CNT_W-1:0];
				REG_GAIN: cfg_q.gain <= pwdata[GAIN_W-1:0];
				REG_MINT: cfg_q.mint <= pwdata[MIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_TOL:  prdata = DATA_W'(cfg_q.tol);
			REG_WIN:  prdata = DATA_W'(cfg_q.win);
			REG_MAXC: prdata = DATA_W'(cfg_q.maxc);
			REG_GAIN: prdata = DATA_W'(cfg_q.gain);
			REG_MINT: prdata = DATA_W'(cfg_q.mint);
			default:  prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// File: src/dtl_ctrl.sv
`default_nettype none
module dtl_ctrl (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire logic                              kind,
	input  wire logic        [dtl_pkg::TMV_W-1:0]  target_mv,
	input  wire logic signed [dtl_pkg::MEAS_W-1:0] measured_q4,
	input  wire dtl_pkg::cfg_t                     cfg,
	output dtl_pkg::dec_t                          dec
);
	import dtl_pkg::*;

	localparam int TW_W = (TMV_W + FRAC_BITS > TGT_W) ? TMV_W + FRAC_BITS : TGT_W;
	localparam logic signed [SP_W-1:0] SP_MAX = {1'b0, {(SP_W-1){1'b1}}};
	localparam logic signed [SP_W-1:0] SP_MIN = {1'b1, {(SP_W-1){1'b0}}};

	phase_t                   phase_q, phase_d;
	logic signed [SP_W-1:0]   setpoint_q, setpoint_d;
	logic        [TGT_W-1:0]  target_q, target_d;
	logic        [CNT_W-1:0]  corr_q, corr_d;

	logic        [TW_W-1:0]   tgt_wide;
	logic        [TGT_W-1:0]  tgt_new;
	logic                     low_tgt;
	logic signed [ERR_W-1:0]  err;
	logic        [ERR_W-1:0]  abs_err;
	logic                     in_win, in_tol, out_of_budget;
	logic signed [SP_W:0]     sp_diff;
	logic signed [SP_W-1:0]   sp_sat;

	assign tgt_wide = TW_W'(target_mv) << FRAC_BITS;
	assign tgt_new  = tgt_wide[TGT_W-1:0];
	assign low_tgt  = target_mv < TMV_W'(cfg.mint);

	assign err     = {measured_q4[MEAS_W-1], measured_q4} - {2'b00, target_q};
	assign abs_err = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
	assign in_win  = abs_err < ERR_W'(cfg.win);
	assign in_tol  = abs_err < ERR_W'(cfg.tol);
	assign out_of_budget = corr_q <= CNT_W'(1);

	assign sp_diff = {setpoint_q[SP_W-1], setpoint_q}
		- {{(SP_W+1-ERR_W){err[ERR_W-1]}}, err};

	always_comb begin
		if (sp_diff[SP_W] != sp_diff[SP_W-1]) begin
			sp_sat = sp_diff[SP_W] ? SP_MIN : SP_MAX;
		end else begin
			sp_sat = sp_diff[SP_W-1:0];
		end
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		if (!kind) begin
			phase_d = low_tgt ? PH_IDLE : PH_CAPTURE;
		end else begin
			case (phase_q)
				PH_IDLE:    phase_d = PH_IDLE;
				PH_CAPTURE: phase_d = in_win ? PH_TRIM : PH_IDLE;
				PH_TRIM:    phase_d = (in_tol || out_of_budget) ? PH_IDLE : PH_TRIM;
				default:    phase_d = PH_IDLE;
			endcase
		end
	end

	// outputs and datapath state
	always_comb begin
		setpoint_d = setpoint_q;
		target_d   = target_q;
		corr_d     = corr_q;
		dec.load   = 1'b0;
		dec.status = ST_IGNORED;
		if (!kind) begin
			target_d   = tgt_new;
			setpoint_d = SP_W'(tgt_new);
			corr_d     = '0;
			dec.load   = 1'b1;
			dec.status = low_tgt ? ST_PASS : ST_TRIM;
		end else begin
			case (phase_q)
				PH_CAPTURE: begin
					if (in_win) begin
						corr_d     = cfg.maxc;
						setpoint_d = sp_sat;
						dec.load   = 1'b1;
						dec.status = ST_TRIM;
					end else begin
						dec.status = ST_FAIL;
					end
				end
				PH_TRIM: begin
					if (in_tol) begin
						dec.status = ST_PASS;
					end else if (out_of_budget) begin
						corr_d     = '0;
						dec.status = ST_FAIL;
					end else begin
						corr_d     = corr_q - CNT_W'(1);
						setpoint_d = sp_sat;
						dec.load   = 1'b1;
						dec.status = ST_TRIM;
					end
				end
				default: dec.status = ST_IGNORED;
			endcase
		end
		dec.sp = setpoint_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			setpoint_q <= '0;
			target_q   <= '0;
			corr_q     <= '0;
		end else if (en) begin
			phase_q    <= phase_d;
			setpoint_q <= setpoint_d;
			target_q   <= target_d;
			corr_q     <= corr_d;
		end
	end

endmodule
`default_nettype wire

// File: src/dtl_code.sv
`default_nettype none
module dtl_code #(
	parameter int DAC_BITS = dtl_pkg::DAC_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire dtl_pkg::dec_t               dec,
	input  wire logic [dtl_pkg::GAIN_W-1:0]  gain,
	output logic      [DAC_BITS-1:0]         dac_code_s3,
	output dtl_pkg::status_t                 status_s3
);
	import dtl_pkg::*;

	localparam int MAG_W  = SP_W - 1;
	localparam int PROD_W = MAG_W + GAIN_W;
	localparam int HI_W   = PROD_W - GAIN_FRAC;
	localparam logic [HI_W-1:0] TOP = HI_W'((64'd1 << DAC_BITS) - 64'd1);

	logic [DAC_BITS-1:0] cur_q;
	logic [PROD_W-1:0]   prod;
	logic [HI_W-1:0]     hi;
	logic                pos;
	logic [DAC_BITS-1:0] code;

	assign pos  = !dec.sp[SP_W-1] && (dec.sp != '0);
	assign prod = dec.sp[MAG_W-1:0] * gain;
	assign hi   = prod[PROD_W-1:GAIN_FRAC];

	always_comb begin
		if (!pos) begin
			code = '0;
		end else if (hi > TOP) begin
			code = TOP[DAC_BITS-1:0];
		end else begin
			code = hi[DAC_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (en && dec.load) begin
			cur_q <= code;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dac_code_s3 <= dec.load ? code : cur_q;
			status_s3   <= dec.status;
		end
	end

endmodule
`default_nettype wire

// File: src/dac_output_trim_loop.sv
`default_nettype none
// DAC output trim loop. Every transaction on the input channel (start with a
// target, or a measurement) gives exactly one result transaction carrying the
// DAC code now applied and a status. One transaction is taken per clock unless
// out_ready stalls the pipeline; a result passes the input register, the control
// stage holding the trim state and the code stage with the gain multiply and
// saturation. The control stage updates phase, setpoint and the correction
// budget once per transaction. The user must write configuration registers on
// the APB port only with no transaction in flight; the block does not enforce it.
module dac_output_trim_loop #(
	parameter int DAC_BITS = dtl_pkg::DAC_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic        [dtl_pkg::ADDR_W-1:0] paddr,
	input  wire logic        [dtl_pkg::DATA_W-1:0] pwdata,
	output logic             [dtl_pkg::DATA_W-1:0] prdata,
	output logic                                   pready,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              kind,
	input  wire logic        [dtl_pkg::TMV_W-1:0]  target_mv,
	input  wire logic signed [dtl_pkg::MEAS_W-1:0] measured_q4,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic             [DAC_BITS-1:0]        dac_code,
	output logic             [1:0]                 status
);
	import dtl_pkg::*;

	cfg_t                     cfg;
	logic                     valid_s1, valid_s2, valid_s3;
	logic                     kind_s1;
	logic        [TMV_W-1:0]  target_s1;
	logic signed [MEAS_W-1:0] meas_s1;
	dec_t                     dec, dec_s2;
	status_t                  status_s3;
	logic                     adv1, adv2, en2, en3;

	assign adv2     = !valid_s3 || out_ready;
	assign adv1     = !valid_s2 || adv2;
	assign in_ready = !valid_s1 || adv1;
	assign en2      = valid_s1 && adv1;
	assign en3      = valid_s2 && adv2;

	assign out_valid = valid_s3;
	assign status    = status_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv1) begin
				valid_s2 <= valid_s1;
			end
			if (adv2) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1   <= kind;
			target_s1 <= target_mv;
			meas_s1   <= measured_q4;
		end
		if (en2) begin
			dec_s2 <= dec;
		end
	end

	dtl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dtl_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en2),
		.kind        (kind_s1),
		.target_mv   (target_s1),
		.measured_q4 (meas_s1),
		.cfg         (cfg),
		.dec         (dec)
	);

	dtl_code #(
		.DAC_BITS (DAC_BITS)
	) u_code (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en3),
		.dec         (dec_s2),
		.gain        (cfg.gain),
		.dac_code_s3 (dac_code),
		.status_s3   (status_s3)
	);

endmodule
`default_nettype wire

// File: test/tb_dac_output_trim_loop.sv
module tb_dac_output_trim_loop;
	import dtl_pkg::*;

	localparam int WD_LIMIT = 4000;
	localparam int CODE_TOP = 4095;
	localparam longint SP_HI = 64'sd8388607;
	localparam longint SP_LO = -64'sd8388608;
	localparam int MEAS_HI = 524287;
	localparam int MEAS_LO = -524288;

	typedef struct {
		logic                     kind;
		logic [TMV_W-1:0]         tmv;
		logic signed [MEAS_W-1:0] meas;
	} trim_cmd_t;

	typedef struct {
		logic [11:0] code;
		status_t     st;
	} trim_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic kind = 1'b0;
	logic [TMV_W-1:0] target_mv = '0;
	logic signed [MEAS_W-1:0] measured_q4 = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [11:0] dac_code;
	logic [1:0] status;

	dac_output_trim_loop dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .target_mv(target_mv), .measured_q4(measured_q4),
		.out_valid(out_valid), .out_ready(out_ready),
		.dac_code(dac_code), .status(status)
	);

	always #4 clk = ~clk;

	// shadow configuration
	logic [TOL_W-1:0]  c_tol  = TOL_RST;
	logic [TOL_W-1:0]  c_win  = WIN_RST;
	logic [CNT_W-1:0]  c_maxc = MAXC_RST;
	logic [GAIN_W-1:0] c_gain = GAIN_RST;
	logic [MIN_W-1:0]  c_mint = MINT_RST;

	// shadow trim state
	phase_t                 m_phase = PH_IDLE;
	logic signed [SP_W-1:0] m_sp = '0;
	logic [TGT_W-1:0]       m_tgt = '0;
	logic [CNT_W-1:0]       m_left = '0;
	logic [11:0]            m_code = '0;

	trim_cmd_t trim_cmds[$];
	trim_res_t want_results[$];
	int n_offered = 0;
	int n_accepted = 0;
	int n_fail = 0;
	int idle_cycles = 0;

	function automatic logic [11:0] gain_code(logic signed [SP_W-1:0] sp);
		longint prod;
		if (sp <= 0)
			return '0;
		prod = (longint'(sp) * longint'(c_gain)) >>> GAIN_FRAC;
		if (prod > CODE_TOP)
			prod = CODE_TOP;
		return prod[11:0];
	endfunction

	function automatic trim_res_t trim_step(trim_cmd_t r);
		trim_res_t res;
		longint err, aerr, sp;
		bit corr;
		res.st = ST_IGNORED;
		corr = 1'b0;
		if (r.kind == 1'b0) begin
			m_tgt = {r.tmv, 4'b0000};
			m_sp = $signed({5'b0, m_tgt});
			m_code = gain_code(m_sp);
			m_left = '0;
			if (r.tmv < c_mint) begin
				m_phase = PH_IDLE;
				res.st = ST_PASS;
			end else begin
				m_phase = PH_CAPTURE;
				res.st = ST_TRIM;
			end
		end else if (m_phase != PH_IDLE) begin
			err = longint'(r.meas) - longint'(m_tgt);
			aerr = (err < 0) ? -err : err;
			if (m_phase == PH_CAPTURE) begin
				if (aerr < longint'(c_win)) begin
					m_left = c_maxc;
					m_phase = PH_TRIM;
					corr = 1'b1;
				end else begin
					m_phase = PH_IDLE;
					res.st = ST_FAIL;
				end
			end else if (aerr < longint'(c_tol)) begin
				m_phase = PH_IDLE;
				res.st = ST_PASS;
			end else if (m_left <= 1) begin
				m_left = '0;
				m_phase = PH_IDLE;
				res.st = ST_FAIL;
			end else begin
				m_left = m_left - 1'b1;
				corr = 1'b1;
			end
			if (corr) begin
				sp = longint'(m_sp) - err;
				if (sp > SP_HI)
					sp = SP_HI;
				if (sp < SP_LO)
					sp = SP_LO;
				m_sp = 24'(sp);
				m_code = gain_code(m_sp);
				res.st = ST_TRIM;
			end
		end
		res.code = m_code;
		return res;
	endfunction

	function automatic int rand_signed(int m);
		int v;
		v = $urandom_range(0, m);
		return ($urandom_range(0, 1) == 1) ? v : -v;
	endfunction

	task automatic push_start(int tmv);
		trim_cmd_t r;
		r.kind = 1'b0;
		r.tmv = tmv[TMV_W-1:0];
		r.meas = 20'($urandom_range(0, 20'hFFFFF));
		trim_cmds.push_back(r);
	endtask

	task automatic push_meas(int v);
		trim_cmd_t r;
		if (v > MEAS_HI)
			v = MEAS_HI;
		if (v < MEAS_LO)
			v = MEAS_LO;
		r.kind = 1'b1;
		r.tmv = 15'($urandom_range(0, 15'h7FFF));
		r.meas = v[MEAS_W-1:0];
		trim_cmds.push_back(r);
	endtask

	// start, capture measurement, then a run of corrections
	task automatic add_session(ref int added);
		int tmv, tq, e, n, mag, w, t, pick;
		bit extreme, up;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			tmv = $urandom_range(0, c_mint);
		else if (pick == 1)
			tmv = ($urandom_range(0, 1) == 1) ? 32767 : 20000;
		else if (pick == 2)
			tmv = $urandom_range(0, 32767);
		else
			tmv = $urandom_range(c_mint, 20000);
		push_start(tmv);
		tq = tmv * 16;
		w = c_win;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			e = w;
		else if (pick == 1)
			e = -w;
		else if (pick == 2)
			e = rand_signed(100000);
		else
			e = (w > 0) ? rand_signed(w - 1) : 0;
		push_meas(tq + e);
		added += 2;
		extreme = ($urandom_range(0, 9) == 0);
		up = 1'($urandom_range(0, 1));
		n = extreme ? 20 : $urandom_range(0, 10);
		t = c_tol;
		for (int i = 0; i < n; i++) begin
			if (extreme) begin
				push_meas(up ? MEAS_HI : MEAS_LO);
			end else begin
				pick = $urandom_range(0, 4);
				case (pick)
					0: e = rand_signed((t > 0) ? t - 1 : 0);
					1: e = ($urandom_range(0, 1) == 1) ? t : -t;
					2: e = rand_signed(2 * t + 50);
					default: e = rand_signed(5000);
				endcase
				push_meas(tq + e);
			end
			added++;
		end
	endtask

	task automatic fill_random(int count);
		int added;
		trim_cmd_t r;
		added = 0;
		while (added < count) begin
			if ($urandom_range(0, 6) == 0) begin
				r.kind = 1'($urandom_range(0, 1));
				r.tmv = 15'($urandom_range(0, 15'h7FFF));
				r.meas = 20'($urandom_range(0, 20'hFFFFF));
				trim_cmds.push_back(r);
				added++;
			end else begin
				add_session(added);
			end
		end
	endtask

	task automatic cfg_write(logic [2:0] idx, logic [DATA_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_TOL:  c_tol = val[TOL_W-1:0];
			REG_WIN:  c_win = val[TOL_W-1:0];
			REG_MAXC: c_maxc = val[CNT_W-1:0];
			REG_GAIN: c_gain = val[GAIN_W-1:0];
			REG_MINT: c_mint = val[MIN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic cfg_all(int tol, int win, int maxc, int gain, int mint);
		cfg_write(REG_TOL, tol);
		cfg_write(REG_WIN, win);
		cfg_write(REG_MAXC, maxc);
		cfg_write(REG_GAIN, gain);
		cfg_write(REG_MINT, mint);
	endtask

	task automatic wait_drained();
		while (trim_cmds.size() != 0 || n_accepted != n_offered || want_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// sender: bursts with random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		trim_cmd_t r;
		if (!(in_valid && n_accepted != n_offered)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (trim_cmds.size() != 0) begin
				r = trim_cmds.pop_front();
				kind <= r.kind;
				target_mv <= r.tmv;
				measured_q4 <= r.meas;
				in_valid <= 1'b1;
				n_offered++;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern
	int seg_left = 0;
	int rx_mode = 0;
	int rx_period = 2;
	int rx_cnt = 0;
	always @(negedge clk) begin
		if (seg_left == 0) begin
			seg_left = $urandom_range(16, 96);
			rx_mode = $urandom_range(0, 3);
			rx_period = $urandom_range(2, 12);
		end else begin
			seg_left--;
		end
		rx_cnt++;
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 1) == 1);
			2: out_ready <= (rx_cnt % rx_period) != 0;
			default: out_ready <= (rx_cnt % rx_period) == 0;
		endcase
	end

	// predict on accept, check on result
	always @(posedge clk) begin
		trim_cmd_t r;
		trim_res_t w;
		if (in_valid && in_ready) begin
			r.kind = kind;
			r.tmv = target_mv;
			r.meas = measured_q4;
			want_results.push_back(trim_step(r));
			n_accepted++;
		end
		if (out_valid && out_ready) begin
			if (want_results.size() == 0) begin
				$error("unexpected result transaction: dac_code %0d status %0d",
					dac_code, status);
				n_fail++;
			end else begin
				w = want_results.pop_front();
				if (dac_code !== w.code) begin
					$error("dac_code mismatch: expected %0d, actual %0d", w.code, dac_code);
					n_fail++;
				end
				if (status !== w.st) begin
					$error("status mismatch: expected %0d, actual %0d", w.st, status);
					n_fail++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WD_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed, reset configuration
		push_meas(0);
		push_start(0);
		push_start(49);
		push_start(50);
		push_meas(800);
		push_meas(810);
		push_start(1000);
		push_meas(16000 + 3200);
		push_start(1000);
		push_meas(16000 - 3199);
		push_meas(16080);
		push_start(32767);
		push_meas(524272);
		repeat (8) push_meas(MEAS_LO);
		push_start(50);
		push_meas(800);
		push_meas(MEAS_HI);
		wait_drained();

		cfg_all(0, 65535, 0, 1048575, 0);
		fill_random(130);
		wait_drained();
		cfg_all(65535, 0, 255, 0, 1023);
		fill_random(110);
		wait_drained();
		cfg_all(16, 800, 3, 14271, 50);
		fill_random(130);
		wait_drained();
		cfg_all(80, 3200, 50, 14271, 50);
		fill_random(130);
		wait_drained();
		cfg_all(200, 20000, 255, 524288, 200);
		fill_random(130);
		wait_drained();
		repeat (3) begin
			cfg_all($urandom_range(0, 400), $urandom_range(0, 8000), $urandom_range(0, 20),
				$urandom_range(0, 1048575), $urandom_range(0, 1023));
			fill_random(125);
			wait_drained();
		end

		if (n_fail == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: files.f
src/dtl_pkg.sv
src/dtl_cfg.sv
src/dtl_ctrl.sv
src/dtl_code.sv
src/dac_output_trim_loop.sv
test/tb_dac_output_trim_loop.sv
